// ===== rtl/mtep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

    // Longest variable-length quantity that is accepted, in bytes.
    localparam int MAX_VLQ_BYTES = 4;
    localparam int VLQ_CNT_W     = $clog2(MAX_VLQ_BYTES + 1);

    localparam int VLQ_W   = 28;
    localparam int KIND_W  = 4;
    localparam int ERR_W   = 2;

    // Event kinds.
    localparam logic [KIND_W-1:0] KIND_NOTEOFF   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_NOTEON    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_POLYPRESS = 4'd2;
    localparam logic [KIND_W-1:0] KIND_CTRL      = 4'd3;
    localparam logic [KIND_W-1:0] KIND_CHANMODE  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_PROGRAM   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_CHANPRESS = 4'd6;
    localparam logic [KIND_W-1:0] KIND_BEND      = 4'd7;
    localparam logic [KIND_W-1:0] KIND_SYSEX     = 4'd8;
    localparam logic [KIND_W-1:0] KIND_META      = 4'd9;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN   = 4'd10;
    localparam logic [KIND_W-1:0] KIND_ERROR     = 4'd11;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_VLQ_LONG  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED = 2'd2;

    // Status bytes.
    localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_CONT = 8'hF7;
    localparam logic [7:0] STATUS_META       = 8'hFF;
    localparam logic [7:0] CTRL_MODE_FIRST   = 8'h78;

    // Opcode nibbles of channel messages.
    localparam logic [3:0] OP_NOTEOFF   = 4'h8;
    localparam logic [3:0] OP_NOTEON    = 4'h9;
    localparam logic [3:0] OP_POLYPRESS = 4'hA;
    localparam logic [3:0] OP_CTRL      = 4'hB;
    localparam logic [3:0] OP_PROGRAM   = 4'hC;
    localparam logic [3:0] OP_CHANPRESS = 4'hD;
    localparam logic [3:0] OP_BEND      = 4'hE;

    typedef struct packed {
        logic              emit;
        logic [KIND_W-1:0] event_kind;
        logic [3:0]        channel;
        logic [7:0]        first_data;
        logic [7:0]        second_data;
        logic [VLQ_W-1:0]  delta_ticks;
        logic [7:0]        meta_type;
        logic [VLQ_W-1:0]  payload_length;
        logic              used_running;
        logic [ERR_W-1:0]  error_code;
    } mtep_result_t;

    // Kind of a channel message; controllers from 0x78 up are channel mode messages.
    function automatic logic [KIND_W-1:0] channel_kind(input logic [7:0] status,
                                                       input logic [7:0] d1);
        logic [KIND_W-1:0] k;
        begin
            case (status[7:4])
                OP_NOTEOFF:   k = KIND_NOTEOFF;
                OP_NOTEON:    k = KIND_NOTEON;
                OP_POLYPRESS: k = KIND_POLYPRESS;
                OP_CTRL:      k = (d1 < CTRL_MODE_FIRST) ? KIND_CTRL : KIND_CHANMODE;
                OP_PROGRAM:   k = KIND_PROGRAM;
                OP_CHANPRESS: k = KIND_CHANPRESS;
                OP_BEND:      k = KIND_BEND;
                default:      k = KIND_UNKNOWN;
            endcase
            return k;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mtep_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtep_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  track_end,
    output mtep_pkg::mtep_result_t     result
);
    import mtep_pkg::*;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_META_TYPE,
        PH_LEN,
        PH_SKIP,
        PH_DATA1,
        PH_DATA2,
        PH_DATA2_RUN,
        PH_DEAD
    } phase_t;

    localparam logic [VLQ_CNT_W-1:0] VLQ_LIMIT = VLQ_CNT_W'(MAX_VLQ_BYTES);

    phase_t               phase_reg, phase_next;
    logic [VLQ_W-1:0]     acc_reg, acc_next;
    logic [VLQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic [VLQ_W-1:0]     delta_reg, delta_next;
    logic [7:0]           running_reg, running_next;
    logic [7:0]           current_reg, current_next;
    logic [7:0]           held_reg, held_next;
    logic [VLQ_W-1:0]     skip_reg, skip_next;

    logic [VLQ_W-1:0]     acc_shift;
    logic [VLQ_CNT_W-1:0] cnt_inc;
    logic                 vlq_done;
    logic                 vlq_long;
    logic [VLQ_W-1:0]     skip_dec;
    logic [KIND_W-1:0]    run_kind;
    logic [KIND_W-1:0]    d1_kind;
    logic                 finished;
    mtep_result_t         res;

    assign acc_shift = {acc_reg[VLQ_W-8:0], data_byte[6:0]};
    assign cnt_inc   = cnt_reg + 1'b1;
    assign vlq_done  = !data_byte[7];
    assign vlq_long  = data_byte[7] && (cnt_inc >= VLQ_LIMIT);
    assign skip_dec  = skip_reg - 1'b1;
    assign run_kind  = channel_kind(running_reg, data_byte);
    assign d1_kind   = channel_kind(current_reg, data_byte);

    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        delta_next   = delta_reg;
        running_next = running_reg;
        current_next = current_reg;
        held_next    = held_reg;
        skip_next    = skip_reg;
        finished     = 1'b0;
        res          = '0;

        case (phase_reg)
            PH_DELTA:
            begin
                acc_next = acc_shift;
                if (vlq_done)
                begin
                    delta_next = acc_shift;
                    phase_next = PH_STATUS;
                end
                else if (vlq_long)
                begin
                    res.emit       = 1'b1;
                    res.event_kind = KIND_ERROR;
                    res.error_code = ERR_VLQ_LONG;
                    phase_next     = PH_DEAD;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            PH_STATUS:
            begin
                if (data_byte == STATUS_SYSEX || data_byte == STATUS_SYSEX_CONT)
                begin
                    current_next = data_byte;
                    running_next = '0;
                    acc_next     = '0;
                    cnt_next     = '0;
                    phase_next   = PH_LEN;
                end
                else if (data_byte == STATUS_META)
                begin
                    current_next = data_byte;
                    running_next = '0;
                    phase_next   = PH_META_TYPE;
                end
                else if (data_byte[7])
                begin
                    current_next = data_byte;
                    running_next = data_byte;
                    if (channel_kind(data_byte, 8'h00) == KIND_UNKNOWN)
                    begin
                        res.emit        = 1'b1;
                        res.event_kind  = KIND_UNKNOWN;
                        res.channel     = data_byte[3:0];
                        res.delta_ticks = delta_reg;
                        finished        = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA1;
                    end
                end
                else
                begin
                    // Data byte in status position: reuse the running status.
                    current_next = running_reg;
                    if (run_kind == KIND_UNKNOWN)
                    begin
                        res.emit         = 1'b1;
                        res.event_kind   = KIND_UNKNOWN;
                        res.channel      = running_reg[3:0];
                        res.delta_ticks  = delta_reg;
                        res.used_running = 1'b1;
                        finished         = 1'b1;
                    end
                    else if (run_kind == KIND_PROGRAM || run_kind == KIND_CHANPRESS)
                    begin
                        res.emit         = 1'b1;
                        res.event_kind   = run_kind;
                        res.channel      = running_reg[3:0];
                        res.first_data   = data_byte;
                        res.delta_ticks  = delta_reg;
                        res.used_running = 1'b1;
                        finished         = 1'b1;
                    end
                    else
                    begin
                        held_next  = data_byte;
                        phase_next = PH_DATA2_RUN;
                    end
                end
            end
            PH_META_TYPE:
            begin
                held_next  = data_byte;
                acc_next   = '0;
                cnt_next   = '0;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                acc_next = acc_shift;
                if (vlq_done)
                begin
                    if (acc_shift == '0)
                    begin
                        res.emit        = 1'b1;
                        res.event_kind  = (current_reg == STATUS_META) ? KIND_META : KIND_SYSEX;
                        res.meta_type   = (current_reg == STATUS_META) ? held_reg : 8'h00;
                        res.delta_ticks = delta_reg;
                        finished        = 1'b1;
                    end
                    else
                    begin
                        skip_next  = acc_shift;
                        phase_next = PH_SKIP;
                    end
                end
                else if (vlq_long)
                begin
                    res.emit       = 1'b1;
                    res.event_kind = KIND_ERROR;
                    res.error_code = ERR_VLQ_LONG;
                    phase_next     = PH_DEAD;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    res.emit           = 1'b1;
                    res.event_kind     = (current_reg == STATUS_META) ? KIND_META : KIND_SYSEX;
                    res.meta_type      = (current_reg == STATUS_META) ? held_reg : 8'h00;
                    res.delta_ticks    = delta_reg;
                    res.payload_length = acc_reg;
                    finished           = 1'b1;
                end
            end
            PH_DATA1:
            begin
                if (d1_kind == KIND_PROGRAM || d1_kind == KIND_CHANPRESS)
                begin
                    res.emit        = 1'b1;
                    res.event_kind  = d1_kind;
                    res.channel     = current_reg[3:0];
                    res.first_data  = data_byte;
                    res.delta_ticks = delta_reg;
                    finished        = 1'b1;
                end
                else
                begin
                    held_next  = data_byte;
                    phase_next = PH_DATA2;
                end
            end
            PH_DATA2, PH_DATA2_RUN:
            begin
                res.emit         = 1'b1;
                res.event_kind   = channel_kind(current_reg, held_reg);
                res.channel      = current_reg[3:0];
                res.first_data   = held_reg;
                res.second_data  = data_byte;
                res.delta_ticks  = delta_reg;
                res.used_running = (phase_reg == PH_DATA2_RUN);
                finished         = 1'b1;
            end
            default:
            begin
                phase_next = PH_DEAD;
            end
        endcase

        if (finished)
        begin
            phase_next = PH_DELTA;
            acc_next   = '0;
            cnt_next   = '0;
        end

        if (track_end)
        begin
            if (!res.emit && phase_next != PH_DEAD)
            begin
                res            = '0;
                res.emit       = 1'b1;
                res.event_kind = KIND_ERROR;
                res.error_code = ERR_TRUNCATED;
            end
            phase_next   = PH_DELTA;
            acc_next     = '0;
            cnt_next     = '0;
            delta_next   = '0;
            running_next = '0;
            current_next = '0;
            held_next    = '0;
            skip_next    = '0;
        end
    end

    assign result = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_DELTA;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            delta_reg   <= '0;
            running_reg <= '0;
            current_reg <= '0;
            held_reg    <= '0;
            skip_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            delta_reg   <= delta_next;
            running_reg <= running_next;
            current_reg <= current_next;
            held_reg    <= held_next;
            skip_reg    <= skip_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/midi_track_event_parser.sv =====
// A beat is held in the input register, and the record that it completes is registered in the output register.
// Throughput: one byte per cycle while the output is not stalled; the input register can take a beat while a
// finished event record waits in the output register.
// Reset: rst_n (asynchronous, active low) clears all valids and the parser state;
// the parser also returns to its reset state after each track's last byte.
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_parser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          track_end,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mtep_pkg::KIND_W-1:0]        event_kind,
    output logic [3:0]                         channel,
    output logic [7:0]                         first_data,
    output logic [7:0]                         second_data,
    output logic [mtep_pkg::VLQ_W-1:0]         delta_ticks,
    output logic [7:0]                         meta_type,
    output logic [mtep_pkg::VLQ_W-1:0]         payload_length,
    output logic                               used_running,
    output logic [mtep_pkg::ERR_W-1:0]         error_code
);
    import mtep_pkg::*;

    // Input register: one beat waiting to be parsed.
    logic         in_valid_reg;
    logic [7:0]   byte_reg;
    logic         end_reg;

    // Output register: one finished event record.
    logic         out_valid_reg;
    mtep_result_t out_reg;

    mtep_result_t parse_res;
    logic         advance;

    // The held byte is parsed whenever the output register can take its result.
    // A byte that completes nothing still needs this, so that records stay in order.
    assign advance  = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !advance;

    mtep_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (byte_reg),
        .track_end (end_reg),
        .result    (parse_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (!(out_valid_reg && out_stall))
            begin
                out_valid_reg <= advance && parse_res.emit;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= data_byte;
            end_reg  <= track_end;
        end
        if (advance && parse_res.emit)
        begin
            out_reg <= parse_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = out_reg.event_kind;
    assign channel        = out_reg.channel;
    assign first_data     = out_reg.first_data;
    assign second_data    = out_reg.second_data;
    assign delta_ticks    = out_reg.delta_ticks;
    assign meta_type      = out_reg.meta_type;
    assign payload_length = out_reg.payload_length;
    assign used_running   = out_reg.used_running;
    assign error_code     = out_reg.error_code;

endmodule

`default_nettype wire

// ===== bench/midi_track_event_parser_test.sv =====
`timescale 1ns / 1ps

module midi_track_event_parser_test;
    import mtep_pkg::*;

    // Parser position within the current event.
    typedef enum logic [3:0] {
        WAIT_DELTA,
        WAIT_STATUS,
        WAIT_META_TYPE,
        WAIT_LENGTH,
        SKIP_PAYLOAD,
        WAIT_FIRST,
        WAIT_SECOND,
        WAIT_SECOND_RUN,
        IGNORE_REST
    } parse_state_t;

    typedef enum logic [1:0] {
        VLQ_MORE,
        VLQ_END,
        VLQ_OVERLONG
    } vlq_step_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [3:0]        chan;
        logic [7:0]        d1;
        logic [7:0]        d2;
        logic [VLQ_W-1:0]  delta;
        logic [7:0]        meta;
        logic [VLQ_W-1:0]  length;
        logic              running;
        logic [ERR_W-1:0]  err;
    } midi_event_t;

    // Tracks the parse of the byte stream and holds the event records still owed.
    class event_tracker_t;
        parse_state_t     state;
        logic [VLQ_W-1:0] vlq_acc;
        int unsigned      vlq_count;
        logic [VLQ_W-1:0] delta_held;
        logic [7:0]       run_status;
        logic [7:0]       cur_status;
        logic [7:0]       held_byte;
        logic [VLQ_W-1:0] skip_left;
        midi_event_t      pending[$];
        int unsigned      failures;
        int unsigned      checked;

        function new();
            clear();
            failures = 0;
            checked  = 0;
        endfunction

        function void clear();
            state      = WAIT_DELTA;
            vlq_acc    = '0;
            vlq_count  = 0;
            delta_held = '0;
            run_status = '0;
            cur_status = '0;
            held_byte  = '0;
            skip_left  = '0;
        endfunction

        function logic [KIND_W-1:0] kind_of(input logic [7:0] status, input logic [7:0] d1);
            case (status[7:4])
                OP_NOTEOFF:   return KIND_NOTEOFF;
                OP_NOTEON:    return KIND_NOTEON;
                OP_POLYPRESS: return KIND_POLYPRESS;
                OP_CTRL:      return (d1 < CTRL_MODE_FIRST) ? KIND_CTRL : KIND_CHANMODE;
                OP_PROGRAM:   return KIND_PROGRAM;
                OP_CHANPRESS: return KIND_CHANPRESS;
                OP_BEND:      return KIND_BEND;
                default:      return KIND_UNKNOWN;
            endcase
        endfunction

        function vlq_step_t vlq_push(input logic [7:0] b);
            int unsigned n;
            n = vlq_count + 1;
            vlq_acc = {vlq_acc[VLQ_W-8:0], b[6:0]};
            if (!b[7])
                return VLQ_END;
            if (n >= MAX_VLQ_BYTES)
                return VLQ_OVERLONG;
            vlq_count = n & 7;
            return VLQ_MORE;
        endfunction

        function midi_event_t error_event(input logic [ERR_W-1:0] code);
            midi_event_t ev;
            ev      = '0;
            ev.kind = KIND_ERROR;
            ev.err  = code;
            return ev;
        endfunction

        function midi_event_t blob_event(input logic [VLQ_W-1:0] len);
            midi_event_t ev;
            ev        = '0;
            ev.delta  = delta_held;
            ev.length = len;
            if (cur_status == STATUS_META)
            begin
                ev.kind = KIND_META;
                ev.meta = held_byte;
            end
            else
            begin
                ev.kind = KIND_SYSEX;
            end
            return ev;
        endfunction

        // Takes one accepted beat; returns 1 when the beat was not in an ignored tail.
        function bit note_beat(input logic [7:0] b, input logic last);
            midi_event_t       ev;
            bit                produced;
            bit                done;
            bit                live;
            vlq_step_t         vs;
            logic [KIND_W-1:0] k;
            ev       = '0;
            produced = 1'b0;
            done     = 1'b0;
            live     = (state != IGNORE_REST);
            case (state)
                WAIT_DELTA:
                begin
                    vs = vlq_push(b);
                    if (vs == VLQ_END)
                    begin
                        delta_held = vlq_acc;
                        state      = WAIT_STATUS;
                    end
                    else if (vs == VLQ_OVERLONG)
                    begin
                        ev       = error_event(ERR_VLQ_LONG);
                        produced = 1'b1;
                        state    = IGNORE_REST;
                    end
                end
                WAIT_STATUS:
                begin
                    if (b == STATUS_SYSEX || b == STATUS_SYSEX_CONT)
                    begin
                        cur_status = b;
                        run_status = '0;
                        vlq_acc    = '0;
                        vlq_count  = 0;
                        state      = WAIT_LENGTH;
                    end
                    else if (b == STATUS_META)
                    begin
                        cur_status = b;
                        run_status = '0;
                        state      = WAIT_META_TYPE;
                    end
                    else if (b[7])
                    begin
                        cur_status = b;
                        run_status = b;
                        if (kind_of(b, 8'h00) == KIND_UNKNOWN)
                        begin
                            ev.kind  = KIND_UNKNOWN;
                            ev.chan  = b[3:0];
                            ev.delta = delta_held;
                            done     = 1'b1;
                        end
                        else
                        begin
                            state = WAIT_FIRST;
                        end
                    end
                    else
                    begin
                        cur_status = run_status;
                        k = kind_of(run_status, b);
                        if (k == KIND_UNKNOWN || k == KIND_PROGRAM || k == KIND_CHANPRESS)
                        begin
                            ev.kind    = k;
                            ev.chan    = run_status[3:0];
                            ev.d1      = (k == KIND_UNKNOWN) ? 8'h00 : b;
                            ev.delta   = delta_held;
                            ev.running = 1'b1;
                            done       = 1'b1;
                        end
                        else
                        begin
                            held_byte = b;
                            state     = WAIT_SECOND_RUN;
                        end
                    end
                end
                WAIT_META_TYPE:
                begin
                    held_byte = b;
                    vlq_acc   = '0;
                    vlq_count = 0;
                    state     = WAIT_LENGTH;
                end
                WAIT_LENGTH:
                begin
                    vs = vlq_push(b);
                    if (vs == VLQ_END)
                    begin
                        if (vlq_acc == '0)
                        begin
                            ev   = blob_event('0);
                            done = 1'b1;
                        end
                        else
                        begin
                            skip_left = vlq_acc;
                            state     = SKIP_PAYLOAD;
                        end
                    end
                    else if (vs == VLQ_OVERLONG)
                    begin
                        ev       = error_event(ERR_VLQ_LONG);
                        produced = 1'b1;
                        state    = IGNORE_REST;
                    end
                end
                SKIP_PAYLOAD:
                begin
                    skip_left = skip_left - VLQ_W'(1);
                    if (skip_left == '0)
                    begin
                        ev   = blob_event(vlq_acc);
                        done = 1'b1;
                    end
                end
                WAIT_FIRST:
                begin
                    k = kind_of(cur_status, b);
                    if (k == KIND_PROGRAM || k == KIND_CHANPRESS)
                    begin
                        ev.kind  = k;
                        ev.chan  = cur_status[3:0];
                        ev.d1    = b;
                        ev.delta = delta_held;
                        done     = 1'b1;
                    end
                    else
                    begin
                        held_byte = b;
                        state     = WAIT_SECOND;
                    end
                end
                WAIT_SECOND, WAIT_SECOND_RUN:
                begin
                    ev.kind    = kind_of(cur_status, held_byte);
                    ev.chan    = cur_status[3:0];
                    ev.d1      = held_byte;
                    ev.d2      = b;
                    ev.delta   = delta_held;
                    ev.running = (state == WAIT_SECOND_RUN);
                    done       = 1'b1;
                end
                default:
                begin
                    state = IGNORE_REST;
                end
            endcase
            if (done)
            begin
                produced  = 1'b1;
                state     = WAIT_DELTA;
                vlq_acc   = '0;
                vlq_count = 0;
            end
            if (last)
            begin
                if (!produced && state != IGNORE_REST)
                begin
                    ev       = error_event(ERR_TRUNCATED);
                    produced = 1'b1;
                end
                clear();
            end
            if (produced)
                pending.push_back(ev);
            return live;
        endfunction

        task report(input string msg);
            failures++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
            if (got !== want)
                report($sformatf("record %0d %s is 0x%0h, expected 0x%0h",
                                 checked, name, got, want));
        endtask

        task check_result(input midi_event_t got);
            midi_event_t want;
            checked++;
            if (pending.size() == 0)
            begin
                report($sformatf("record %0d of kind %0d arrived with none owed",
                                 checked, got.kind));
                return;
            end
            want = pending.pop_front();
            compare_field("event_kind", 32'(got.kind), 32'(want.kind));
            compare_field("channel", 32'(got.chan), 32'(want.chan));
            compare_field("first_data", 32'(got.d1), 32'(want.d1));
            compare_field("second_data", 32'(got.d2), 32'(want.d2));
            compare_field("delta_ticks", 32'(got.delta), 32'(want.delta));
            compare_field("meta_type", 32'(got.meta), 32'(want.meta));
            compare_field("payload_length", 32'(got.length), 32'(want.length));
            compare_field("used_running", 32'(got.running), 32'(want.running));
            compare_field("error_code", 32'(got.err), 32'(want.err));
        endtask
    endclass

    // Bytes of random tracks to send, spread evenly over the three pressure profiles.
    localparam int RANDOM_BEATS   = 1750;
    // Far more than the slowest profile needs to send every beat.
    localparam int TIMEOUT_CYCLES = 400000;
    // A record passes the input and output registers after its completing beat; allow a margin.
    localparam int DRAIN_CYCLES   = 12;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [7:0]           data_byte = 8'h00;
    logic                 track_end = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [KIND_W-1:0]    event_kind;
    logic [3:0]           channel;
    logic [7:0]           first_data;
    logic [7:0]           second_data;
    logic [VLQ_W-1:0]     delta_ticks;
    logic [7:0]           meta_type;
    logic [VLQ_W-1:0]     payload_length;
    logic                 used_running;
    logic [ERR_W-1:0]     error_code;

    int unsigned  send_idle_pct  = 23;
    int unsigned  recv_stall_pct = 78;
    int unsigned  cycle_count    = 0;
    int unsigned  beats_sent     = 0;
    int unsigned  tracks_sent    = 0;

    // The track under construction, and the running status the generator believes is held.
    logic [7:0]   track_bytes[$];
    logic [7:0]   gen_running;

    event_tracker_t tracker;

    midi_track_event_parser u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .track_end      (track_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .channel        (channel),
        .first_data     (first_data),
        .second_data    (second_data),
        .delta_ticks    (delta_ticks),
        .meta_type      (meta_type),
        .payload_length (payload_length),
        .used_running   (used_running),
        .error_code     (error_code)
    );

    always #6 clk = ~clk;

    // A run that hangs, whether on a stuck handshake or a record that never comes, ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d records still owed",
                     cycle_count, tracker.pending.size());
            $display("FAIL midi_track_event_parser");
            $finish;
        end
    end

    // Receiver side. Every record taken at an edge is checked against the oldest one owed,
    // and the stall for the next edge is drawn fresh. Outputs are read in the active region
    // of the edge, so they hold the values the block presented before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result({event_kind, channel, first_data, second_data, delta_ticks,
                                  meta_type, payload_length, used_running, error_code});
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Presents one beat and returns at the edge that takes it. While the sender idles, the
    // payload carries noise so the block is seen to ignore it. Valid is never lowered between
    // two back-to-back beats, so each signal gets at most one assignment per edge.
    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'($urandom);
            track_end <= 1'($urandom);
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        track_end <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (tracker.note_beat(b, last))
            beats_sent++;
    endtask

    // Sends the built track; its last byte carries the end-of-track flag.
    task automatic send_track();
        foreach (track_bytes[i])
            send_beat(track_bytes[i], i == track_bytes.size() - 1);
        tracks_sent++;
    endtask

    // Appends a VLQ of exactly nbytes bytes; leading zero groups make non-minimal encodings.
    task automatic put_vlq(input logic [VLQ_W-1:0] value, input int unsigned nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            track_bytes.push_back({i != 0, 7'(value >> (7 * i))});
    endtask

    // Delta times are mostly short, but all four lengths and the full value range appear.
    task automatic put_delta();
        int unsigned pick;
        int unsigned nb;
        pick = $urandom_range(99);
        nb   = (pick < 55) ? 1 : (pick < 75) ? 2 : (pick < 90) ? 3 : 4;
        put_vlq(VLQ_W'($urandom) & ((28'h1 << (7 * nb)) - 1), nb);
    endtask

    // Data bytes are normally below 0x80; now and then one has bit 7 set, which the
    // block must take as data all the same.
    function automatic logic [7:0] data_value();
        return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(127));
    endfunction

    // A channel message, either with its own status byte or leaning on running status.
    // Under running status the first byte must stay below 0x80 or it would read as status.
    task automatic put_channel_event(input bit own_status);
        logic [7:0] d1;
        logic [3:0] op;
        if (own_status)
        begin
            gen_running = {4'($urandom_range(8, 14)), 4'($urandom)};
            track_bytes.push_back(gen_running);
            d1 = data_value();
        end
        else
        begin
            d1 = 8'($urandom_range(127));
        end
        op = gen_running[7:4];
        // Controllers at and above the channel-mode boundary get a fair share.
        if (op == OP_CTRL && $urandom_range(2) == 0)
            d1 = 8'($urandom_range(CTRL_MODE_FIRST, 8'h7F));
        track_bytes.push_back(d1);
        // Program change and channel pressure take one data byte; so does a data byte
        // that arrives with no usable running status.
        if (op >= OP_NOTEOFF && op != OP_PROGRAM && op != OP_CHANPRESS && op != 4'hF)
            track_bytes.push_back(data_value());
    endtask

    // A sysex or meta event. Lengths stay small so payloads are cheap to skip, and some
    // length fields are padded out to several bytes.
    task automatic put_blob_event(input bit is_meta);
        int unsigned len;
        int unsigned pad;
        if (is_meta)
        begin
            track_bytes.push_back(STATUS_META);
            track_bytes.push_back(8'($urandom));
        end
        else
        begin
            track_bytes.push_back($urandom_range(1) ? STATUS_SYSEX : STATUS_SYSEX_CONT);
        end
        len = ($urandom_range(9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
        pad = ($urandom_range(4) == 0) ? $urandom_range(1, MAX_VLQ_BYTES - 1) : 0;
        put_vlq(VLQ_W'(len), pad + 1);
        repeat (len)
            track_bytes.push_back(8'($urandom));
        gen_running = 8'h00;
    endtask

    // A system status other than sysex or meta; it completes at once and becomes the
    // running status, so later bare data bytes find no usable status.
    task automatic put_system_status();
        logic [7:0] s;
        do
            s = 8'($urandom_range(8'hF1, 8'hFE));
        while (s == STATUS_SYSEX_CONT);
        track_bytes.push_back(s);
        gen_running = s;
    endtask

    // Most tracks are well formed with random content. The rest are cut short, hit an
    // overlong VLQ, announce a payload far longer than the track, or end in noise.
    task automatic build_track();
        int unsigned n_events;
        int unsigned pick;
        int unsigned cut;
        track_bytes.delete();
        gen_running = 8'h00;
        n_events = $urandom_range(1, 10);
        repeat (n_events)
        begin
            pick = $urandom_range(99);
            put_delta();
            if (pick < 45)
                put_channel_event(1'b1);
            else if (pick < 65)
                put_channel_event(1'b0);
            else if (pick < 75)
                put_blob_event(1'b0);
            else if (pick < 87)
                put_blob_event(1'b1);
            else
                put_system_status();
        end
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            cut = $urandom_range(1, track_bytes.size());
            while (track_bytes.size() > cut)
                void'(track_bytes.pop_back());
        end
        else if (pick < 16)
        begin
            // Overlong VLQ, either in the delta time or in a length field, then a tail
            // that the block must ignore.
            if ($urandom_range(1))
            begin
                put_delta();
                track_bytes.push_back(STATUS_SYSEX);
            end
            repeat (MAX_VLQ_BYTES)
                track_bytes.push_back(8'($urandom_range(128, 255)));
            repeat ($urandom_range(0, 3))
                track_bytes.push_back(8'($urandom));
        end
        else if (pick < 19)
        begin
            // The largest length there is, so the track ends inside the payload.
            put_delta();
            track_bytes.push_back(STATUS_META);
            track_bytes.push_back(8'($urandom));
            put_vlq({VLQ_W{1'b1}}, MAX_VLQ_BYTES);
            repeat ($urandom_range(0, 4))
                track_bytes.push_back(8'($urandom));
        end
        else if (pick < 22)
        begin
            repeat ($urandom_range(1, 8))
                track_bytes.push_back(8'($urandom));
        end
    endtask

    initial
    begin
        int unsigned directed_beats;
        tracker = new();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed track: a bare data byte at track start (no running status yet), the
        // largest delta time with a data byte that has bit 7 set, running status, the
        // channel-mode boundary, a program change that takes one byte, a system status
        // that completes at once, and a zero-length meta event that closes the track.
        track_bytes = '{8'h00, 8'h12,
                        8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h9F, 8'h00, 8'hFF,
                        8'h00, 8'h40, 8'h7F,
                        8'h00, 8'hBF, 8'h78, 8'h00,
                        8'h00, 8'hC0, 8'h05,
                        8'h00, 8'hF3,
                        8'h00, STATUS_META, 8'h2F, 8'h00};
        send_track();
        // Overlong delta time; the byte after it is ignored and no second error follows.
        track_bytes = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h55};
        send_track();
        // A track that ends inside the length field of a sysex event.
        track_bytes = '{8'h00, STATUS_SYSEX, 8'h83};
        send_track();
        directed_beats = beats_sent;

        // Three pressure profiles: a slow receiver, a slow sender, then full rate.
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct  = (p == 0) ? 23 : (p == 1) ? 78 : 0;
            recv_stall_pct = (p == 0) ? 78 : (p == 1) ? 23 : 0;
            while (beats_sent < directed_beats + RANDOM_BEATS * (p + 1) / 3)
            begin
                build_track();
                send_track();
            end
        end
        in_valid <= 1'b0;

        // Wait for every owed record, then a little longer so a stray extra one is seen.
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d tracks (%0d parsed bytes) under three handshake profiles;",
                 tracks_sent, beats_sent);
        $display("checked %0d event records, %0d mismatches.",
                 tracker.checked, tracker.failures);
        if (tracker.failures == 0)
            $display("PASS midi_track_event_parser");
        else
            $display("FAIL midi_track_event_parser");
        $finish;
    end

endmodule
